### sv/bda_pkg.sv
// ----------------------------------------------------------------------------
// bda_pkg
// Shared types and constants for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
package bda_pkg;

    localparam int VALUE_W    = 32;
    localparam int BCD_DIGITS = 10;
    localparam int NIBBLE_W   = 4;
    localparam int BCD_W      = BCD_DIGITS * NIBBLE_W;
    localparam int CHAR_W     = 6;
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(BCD_DIGITS + 1);

    // The upper two bits of an ASCII digit code in six bits.
    localparam logic [CHAR_W-NIBBLE_W-1:0] ASCII_DIGIT_HI = 2'b11;

    typedef struct packed {
        logic             valid;
        logic [BCD_W-1:0] bcd;
    } bda_bcd_t;

endpackage

### sv/binary_to_decimal_ascii.sv
// A value passes through 32 shift-add-3 steps, a handoff to the emitter, up to
// nine leading-zero skips, entry into emission, and a load into the output
// register before its first digit appears.
// The double dabble loop takes a new value only after handing off the last one;
// digits of one value leave at one per cycle while the output is taken.
// Reset (rst_n, asynchronous, active low) empties both stages and the output.
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// Converts an unsigned 32-bit value into ASCII decimal digits, most
// significant first, without leading zeros, flagging the last digit.
// ----------------------------------------------------------------------------
module binary_to_decimal_ascii (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [bda_pkg::VALUE_W-1:0]   value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bda_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last_digit
);
    import bda_pkg::*;

    bda_bcd_t conv;
    logic     conv_ready;

    bda_dabble u_dabble (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .conv       (conv),
        .conv_ready (conv_ready)
    );

    bda_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .conv       (conv),
        .conv_ready (conv_ready),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

endmodule

### sv/bda_dabble.sv
// ----------------------------------------------------------------------------
// bda_dabble
// Serial double dabble: shifts the binary value into a BCD register one bit
// per cycle, adjusting every digit of five or more by three before a shift.
// ----------------------------------------------------------------------------
module bda_dabble (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [bda_pkg::VALUE_W-1:0] value,
    output bda_pkg::bda_bcd_t         conv,
    input  logic                      conv_ready
);
    import bda_pkg::*;

    logic                busy_reg,  busy_next;
    logic                done_reg,  done_next;
    logic [STEP_W-1:0]   cnt_reg,   cnt_next;
    logic [VALUE_W-1:0]  bin_reg,   bin_next;
    logic [BCD_W-1:0]    bcd_reg,   bcd_next;
    logic [BCD_W-1:0]    adjusted;

    assign in_ready   = !busy_reg && !done_reg;
    assign conv.valid = done_reg;
    assign conv.bcd   = bcd_reg;

    always_comb
    begin
        logic [NIBBLE_W-1:0] nib;
        adjusted = '0;
        for (int i = 0; i < BCD_DIGITS; i++)
        begin
            nib = bcd_reg[i*NIBBLE_W +: NIBBLE_W];
            if (nib >= NIBBLE_W'(5))
            begin
                nib = nib + NIBBLE_W'(3);
            end
            adjusted[i*NIBBLE_W +: NIBBLE_W] = nib;
        end
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = done_reg;
        cnt_next  = cnt_reg;
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        if (in_valid && in_ready)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            bin_next  = value;
            bcd_next  = '0;
        end
        else if (busy_reg)
        begin
            bcd_next = {adjusted[BCD_W-2:0], bin_reg[VALUE_W-1]};
            bin_next = {bin_reg[VALUE_W-2:0], 1'b0};
            cnt_next = cnt_reg + STEP_W'(1);
            if (cnt_reg == STEP_W'(VALUE_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
        else if (done_reg && conv_ready)
        begin
            done_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

endmodule

### sv/bda_emit.sv
// ----------------------------------------------------------------------------
// bda_emit
// Digit emitter: drops leading zero digits one per cycle, then shifts the
// remaining digits out most significant first into the output register.
// ----------------------------------------------------------------------------
module bda_emit (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bda_pkg::bda_bcd_t             conv,
    output logic                          conv_ready,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [bda_pkg::CHAR_W-1:0]    digit_char,
    output logic                          last_digit
);
    import bda_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SKIP = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [REM_W-1:0]    rem_reg,   rem_next;
    logic [BCD_W-1:0]    bcd_reg,   bcd_next;
    logic                valid_reg, valid_next;
    logic [CHAR_W-1:0]   char_reg,  char_next;
    logic                last_reg,  last_next;
    logic [NIBBLE_W-1:0] top;
    logic                out_free;

    assign top        = bcd_reg[BCD_W-1 -: NIBBLE_W];
    assign out_free   = !valid_reg || out_ready;
    assign conv_ready = (state_reg == ST_IDLE);
    assign out_valid  = valid_reg;
    assign digit_char = char_reg;
    assign last_digit = last_reg;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        bcd_next   = bcd_reg;
        valid_next = valid_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (conv.valid)
                begin
                    bcd_next   = conv.bcd;
                    rem_next   = REM_W'(BCD_DIGITS);
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top == '0 && rem_reg != REM_W'(1))
                begin
                    bcd_next = {bcd_reg[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    rem_next = rem_reg - REM_W'(1);
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    valid_next = 1'b1;
                    char_next  = {ASCII_DIGIT_HI, top};
                    last_next  = (rem_reg == REM_W'(1));
                    bcd_next   = {bcd_reg[BCD_W-NIBBLE_W-1:0], {NIBBLE_W{1'b0}}};
                    rem_next   = rem_reg - REM_W'(1);
                    if (rem_reg == REM_W'(1))
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            rem_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bcd_reg  <= bcd_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

### sv/bda_checker.sv
// ----------------------------------------------------------------------------
// bda_checker
// Port-level checks for the binary to decimal ASCII converter.
// ----------------------------------------------------------------------------
module bda_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    input  logic                          in_ready,
    input  logic                          out_valid,
    input  logic                          out_ready,
    input  logic [bda_pkg::CHAR_W-1:0]    digit_char,
    input  logic                          last_digit
);
    import bda_pkg::*;

    // A stalled output beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(digit_char)
            && $stable(last_digit))
        else $error("output beat changed while stalled");

    // Every character is an ASCII decimal digit.
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> digit_char[CHAR_W-1 -: 2] == ASCII_DIGIT_HI
            && digit_char[NIBBLE_W-1:0] <= NIBBLE_W'(9))
        else $error("character is not a decimal digit");

    // The converter is busy for the cycle after it takes a value.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while conversion in progress");

endmodule

bind binary_to_decimal_ascii bda_checker u_bda_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .digit_char (digit_char),
    .last_digit (last_digit)
);

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Feeds 32-bit values to the binary to decimal ASCII converter and checks
// every digit beat against digits worked out independently in the bench,
// under changing back-pressure, one long receiver hold-off, and no idling.
// ----------------------------------------------------------------------------
module testbench;

    import bda_pkg::*;

    localparam int CYCLE_LIMIT       = 200000;
    localparam int LONG_HOLD_CYCLES  = 600;
    localparam int PRESSURE_VALUES   = 8;
    localparam int RANDOM_PER_PHASE  = 30;
    localparam int DRAIN_CYCLES      = 60;
    localparam int DECIMAL_BASE      = 10;
    localparam logic [CHAR_W-1:0] ASCII_ZERO = 6'd48;

    localparam logic [VALUE_W-1:0] DIRECTED_VALUES [22] = '{
        32'd0, 32'd1, 32'd9, 32'd10, 32'd11, 32'd99, 32'd100, 32'd101,
        32'd999, 32'd1000, 32'd65535, 32'd99999999, 32'd100000000,
        32'd999999999, 32'd1000000000, 32'd2147483647, 32'd2147483648,
        32'hAAAAAAAA, 32'h55555555, 32'd1234567890, 32'd4294967294,
        32'd4294967295
    };

    typedef struct packed {
        logic [CHAR_W-1:0] code;
        logic              last;
    } digit_beat_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    logic [VALUE_W-1:0]  value = '0;
    logic                out_valid;
    logic                out_ready = 1'b0;
    logic [CHAR_W-1:0]   digit_char;
    logic                last_digit;

    logic [VALUE_W-1:0]  pending_values[$];
    digit_beat_t         expected_digits[$];
    int unsigned         sender_idle_pct = 11;
    int unsigned         receiver_idle_pct = 59;
    int                  hold_requests = 0;
    int                  hold_served = 0;
    int                  hold_left = 0;
    int                  error_count = 0;
    int                  cycle_count = 0;

    binary_to_decimal_ascii uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .value      (value),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .digit_char (digit_char),
        .last_digit (last_digit)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    function automatic void predict_digits(input logic [VALUE_W-1:0] number);
        logic [NIBBLE_W-1:0] digits [BCD_DIGITS];
        logic [VALUE_W-1:0]  rest;
        int                  count;
        digit_beat_t         beat;
        rest  = number;
        count = 0;
        do
        begin
            digits[count] = NIBBLE_W'(rest % DECIMAL_BASE);
            rest = rest / DECIMAL_BASE;
            count++;
        end
        while (rest != 0);
        for (int k = count - 1; k >= 0; k--)
        begin
            beat.code = ASCII_ZERO + CHAR_W'(digits[k]);
            beat.last = (k == 0);
            expected_digits.push_back(beat);
        end
    endfunction

    function automatic longint unsigned power_of_ten(input int exponent);
        longint unsigned result;
        result = 1;
        for (int i = 0; i < exponent; i++)
        begin
            result = result * DECIMAL_BASE;
        end
        return result;
    endfunction

    // Values are spread over digit counts and the edges around powers of ten,
    // with a share of plain 32-bit values so that every bit toggles.
    function automatic logic [VALUE_W-1:0] random_value();
        int unsigned     width;
        longint unsigned lo;
        longint unsigned hi;
        case ($urandom_range(3, 0))
            0:
            begin
                return $urandom;
            end
            1:
            begin
                lo = power_of_ten($urandom_range(9, 1));
                return VALUE_W'(lo + $urandom_range(2, 0) - 1);
            end
            default:
            begin
                width = $urandom_range(BCD_DIGITS, 1);
                lo = (width == 1) ? 0 : power_of_ten(width - 1);
                hi = power_of_ten(width) - 1;
                if (hi > 64'hFFFF_FFFF)
                begin
                    hi = 64'hFFFF_FFFF;
                end
                return $urandom_range(hi[31:0], lo[31:0]);
            end
        endcase
    endfunction

    task automatic queue_random_values(input int count);
        for (int i = 0; i < count; i++)
        begin
            pending_values.push_back(random_value());
        end
    endtask

    task automatic wait_drained();
        while (pending_values.size() != 0 || in_valid || expected_digits.size() != 0)
        begin
            @(negedge clk);
        end
    endtask

    // Sender: predicts on each accepted beat and offers the next value.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            value    <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                predict_digits(value);
            end
            if (!in_valid || in_ready)
            begin
                if (pending_values.size() != 0 && $urandom_range(99, 0) >= sender_idle_pct)
                begin
                    in_valid <= 1'b1;
                    value    <= pending_values.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Receiver: checks each accepted digit beat and drives back-pressure.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_digits.size() == 0)
                begin
                    report_mismatch($sformatf("unexpected digit beat, char %0d last %0b",
                                              digit_char, last_digit));
                end
                else
                begin
                    if (digit_char !== expected_digits[0].code)
                    begin
                        report_mismatch($sformatf("digit_char %0d, expected %0d",
                                                  digit_char, expected_digits[0].code));
                    end
                    if (last_digit !== expected_digits[0].last)
                    begin
                        report_mismatch($sformatf("last_digit %0b, expected %0b",
                                                  last_digit, expected_digits[0].last));
                    end
                    void'(expected_digits.pop_front());
                end
            end
            if (hold_served != hold_requests)
            begin
                hold_served <= hold_requests;
                hold_left   <= LONG_HOLD_CYCLES;
                out_ready   <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99, 0) >= receiver_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (DIRECTED_VALUES[i])
        begin
            pending_values.push_back(DIRECTED_VALUES[i]);
        end
        wait_drained();

        // The receiver stops for a long stretch while values keep coming, so
        // the converter fills up and has to stall its input.
        hold_requests = hold_requests + 1;
        queue_random_values(PRESSURE_VALUES);
        wait_drained();

        queue_random_values(RANDOM_PER_PHASE);
        wait_drained();

        sender_idle_pct   = 59;
        receiver_idle_pct = 11;
        queue_random_values(RANDOM_PER_PHASE);
        wait_drained();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        queue_random_values(RANDOM_PER_PHASE);
        wait_drained();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
